// ----- design/cla_pkg.sv -----
// Shared types, codes and constants of the console line assembler.
`default_nettype none

package cla_pkg;

  localparam int LINE_MAX  = 32;
  localparam int ADDR_W    = $clog2(LINE_MAX);
  localparam int CNT_W     = 6;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 6;
  localparam int TOT_W     = 32;

  localparam logic [7:0] CH_BS = 8'd8;
  localparam logic [7:0] CH_LF = 8'd10;
  localparam logic [7:0] CH_CR = 8'd13;
  localparam logic [7:0] CH_SP = 8'd32;

  localparam logic [CFG_IDX_W-1:0] CFG_ECHO  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 2'd1;

  typedef logic [3:0] step_t;

  localparam step_t S_IDLE     = 4'd0;
  localparam step_t S_OTH      = 4'd1;
  localparam step_t S_OTH_ECHO = 4'd2;
  localparam step_t S_BS       = 4'd3;
  localparam step_t S_BS_E1    = 4'd4;
  localparam step_t S_BS_E2    = 4'd5;
  localparam step_t S_BS_E3    = 4'd6;
  localparam step_t S_CR       = 4'd7;
  localparam step_t S_CR_E1    = 4'd8;
  localparam step_t S_CR_E2    = 4'd9;
  localparam step_t S_RD       = 4'd10;
  localparam step_t S_SEND     = 4'd11;
  localparam step_t S_END      = 4'd12;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_STORE,
    ACT_BACK,
    ACT_CLOSE,
    ACT_ADV
  } act_e;

  typedef enum logic [2:0] {
    SRC_RX,
    SRC_SP,
    SRC_BS,
    SRC_LF,
    SRC_MEM,
    SRC_ZERO
  } src_e;

  typedef enum logic [1:0] {
    KIND_ECHO = 2'd0,
    KIND_LINE = 2'd1,
    KIND_END  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    C_ALWAYS,
    C_ECHO,
    C_AT_END,
    C_DISPATCH
  } cond_e;

  typedef enum logic [1:0] {
    CLS_OTHER,
    CLS_BS,
    CLS_CR,
    CLS_LF
  } cls_e;

  typedef struct packed {
    act_e  act;
    logic  emit;
    src_e  src;
    kind_e kind;
    logic  last;
    cond_e cond;
    step_t tgt;
    step_t alt;
  } uword_t;

  typedef struct packed {
    logic   fire;
    uword_t w;
  } ctrl_t;

  typedef struct packed {
    logic echo;
    logic at_end;
    logic out_busy;
    logic accept;
    cls_e cls;
  } stat_t;

endpackage

`default_nettype wire

// ----- design/console_line_assembler.sv -----
// Console line assembler top level: sequencer, datapath and checks.
//
// Characters enter on the s_axis channel one transaction at a time; results
// leave on m_axis, each with its kind in tuser and tlast on the final result
// of one character. Settings are written through the cfg channel, which is
// always ready; write only while no character is in flight.
// The line store has one read port, so on a carriage return the control
// program spends two steps per line byte (address, send). Input is
// accepted only when the program is back at its idle step.
// Each result sits in a single output register; while the receiver holds
// tready low the program stops at its next send step and accepts nothing.
// Reset empties the line, clears the totals, turns echo off and sets the
// line limit to 32. Stored bytes are not cleared; only written ones are read.
`default_nettype none

module console_line_assembler
  import cla_pkg::*;
(
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  s_axis_tvalid,
  output logic                 s_axis_tready,
  input  wire  [7:0]           s_axis_tdata,   // [7:0] rx_byte
  output logic                 m_axis_tvalid,
  input  wire                  m_axis_tready,
  // [7:0] out_byte, [13:8] line_length, [45:14] chars_seen,
  // [77:46] chars_lost, [109:78] lines_done, [111:110] zero
  output logic [111:0]         m_axis_tdata,
  output logic                 m_axis_tlast,
  output logic [1:0]           m_axis_tuser,   // [1:0] kind
  input  wire                  cfg_valid_i,
  output logic                 cfg_ready_o,
  input  wire  [CFG_IDX_W-1:0] cfg_index_i,
  input  wire  [CFG_DAT_W-1:0] cfg_data_i
);

  ctrl_t            ctrl;
  stat_t            stat;
  logic             accept;
  kind_e            okind;
  logic [7:0]       obyte;
  logic [CNT_W-1:0] olen;
  logic [TOT_W-1:0] oseen, olost, olines;

  assign accept      = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o = 1'b1;

  cla_useq u_useq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .stat_i     (stat),
    .ctrl_o     (ctrl),
    .in_ready_o (s_axis_tready)
  );

  cla_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .accept_i    (accept),
    .rx_i        (s_axis_tdata),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (m_axis_tready),
    .stat_o      (stat),
    .out_valid_o (m_axis_tvalid),
    .out_kind_o  (okind),
    .out_byte_o  (obyte),
    .out_len_o   (olen),
    .out_last_o  (m_axis_tlast),
    .out_seen_o  (oseen),
    .out_lost_o  (olost),
    .out_lines_o (olines)
  );

  assign m_axis_tuser = okind;
  assign m_axis_tdata = {2'b00, olines, olost, oseen, olen, obyte};

  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == KIND_END) |-> m_axis_tlast)
    else $error("line end without last");

  a_line_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == KIND_LINE) |-> !m_axis_tlast)
    else $error("line byte marked last");

  a_len_only_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != KIND_END) |-> (m_axis_tdata[13:8] == '0))
    else $error("length on non-end result");

  a_end_zero_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == KIND_END) |-> (m_axis_tdata[7:0] == 8'd0))
    else $error("line end carries a byte");

endmodule

`default_nettype wire

// ----- design/cla_useq.sv -----
// Microcode sequencer: control store, step counter and jump logic.
`default_nettype none

module cla_useq
  import cla_pkg::*;
(
  input  wire   clk_i,
  input  wire   rst_ni,
  input  stat_t stat_i,
  output ctrl_t ctrl_o,
  output logic  in_ready_o
);

  function automatic uword_t rom(input step_t a);
    uword_t u;
    u = '{ACT_NONE, 1'b0, SRC_ZERO, KIND_ECHO, 1'b0, C_ALWAYS, S_IDLE, S_IDLE};
    case (a)
      S_IDLE:     u = '{ACT_NONE,  1'b0, SRC_ZERO, KIND_ECHO, 1'b0, C_DISPATCH, S_IDLE, S_IDLE};
      S_OTH:      u = '{ACT_STORE, 1'b0, SRC_ZERO, KIND_ECHO, 1'b0, C_ECHO, S_OTH_ECHO, S_IDLE};
      S_OTH_ECHO: u = '{ACT_NONE,  1'b1, SRC_RX,   KIND_ECHO, 1'b1, C_ALWAYS, S_IDLE, S_IDLE};
      S_BS:       u = '{ACT_BACK,  1'b0, SRC_ZERO, KIND_ECHO, 1'b0, C_ECHO, S_BS_E1, S_IDLE};
      S_BS_E1:    u = '{ACT_NONE,  1'b1, SRC_RX,   KIND_ECHO, 1'b0, C_ALWAYS, S_BS_E2, S_BS_E2};
      S_BS_E2:    u = '{ACT_NONE,  1'b1, SRC_SP,   KIND_ECHO, 1'b0, C_ALWAYS, S_BS_E3, S_BS_E3};
      S_BS_E3:    u = '{ACT_NONE,  1'b1, SRC_BS,   KIND_ECHO, 1'b1, C_ALWAYS, S_IDLE, S_IDLE};
      S_CR:       u = '{ACT_CLOSE, 1'b0, SRC_ZERO, KIND_ECHO, 1'b0, C_ECHO, S_CR_E1, S_RD};
      S_CR_E1:    u = '{ACT_NONE,  1'b1, SRC_RX,   KIND_ECHO, 1'b0, C_ALWAYS, S_CR_E2, S_CR_E2};
      S_CR_E2:    u = '{ACT_NONE,  1'b1, SRC_LF,   KIND_ECHO, 1'b0, C_ALWAYS, S_RD, S_RD};
      S_RD:       u = '{ACT_NONE,  1'b0, SRC_ZERO, KIND_ECHO, 1'b0, C_AT_END, S_END, S_SEND};
      S_SEND:     u = '{ACT_ADV,   1'b1, SRC_MEM,  KIND_LINE, 1'b0, C_ALWAYS, S_RD, S_RD};
      S_END:      u = '{ACT_NONE,  1'b1, SRC_ZERO, KIND_END,  1'b1, C_ALWAYS, S_IDLE, S_IDLE};
      default:    u = '{ACT_NONE,  1'b0, SRC_ZERO, KIND_ECHO, 1'b0, C_ALWAYS, S_IDLE, S_IDLE};
    endcase
    return u;
  endfunction

  step_t  upc_q, upc_d;
  step_t  nxt;
  uword_t w;
  logic   fire;

  always_comb begin
    w    = rom(upc_q);
    fire = !(w.emit && stat_i.out_busy);
    case (w.cond)
      C_ALWAYS: nxt = w.tgt;
      C_ECHO:   nxt = stat_i.echo ? w.tgt : w.alt;
      C_AT_END: nxt = stat_i.at_end ? w.tgt : w.alt;
      C_DISPATCH: begin
        if (!stat_i.accept) begin
          nxt = S_IDLE;
        end else begin
          case (stat_i.cls)
            CLS_BS:  nxt = S_BS;
            CLS_CR:  nxt = S_CR;
            CLS_LF:  nxt = S_IDLE;
            default: nxt = S_OTH;
          endcase
        end
      end
      default: nxt = S_IDLE;
    endcase
    upc_d = fire ? nxt : upc_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= S_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

  assign ctrl_o     = '{fire: fire, w: w};
  assign in_ready_o = (upc_q == S_IDLE);

endmodule

`default_nettype wire

// ----- design/cla_datapath.sv -----
// Datapath: line store, fill and read index, totals, settings and result register.
`default_nettype none

module cla_datapath
  import cla_pkg::*;
(
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  ctrl_t                ctrl_i,
  input  wire                  accept_i,
  input  wire  [7:0]           rx_i,
  input  wire                  cfg_valid_i,
  input  wire  [CFG_IDX_W-1:0] cfg_index_i,
  input  wire  [CFG_DAT_W-1:0] cfg_data_i,
  input  wire                  out_ready_i,
  output stat_t                stat_o,
  output logic                 out_valid_o,
  output kind_e                out_kind_o,
  output logic [7:0]           out_byte_o,
  output logic [CNT_W-1:0]     out_len_o,
  output logic                 out_last_o,
  output logic [TOT_W-1:0]     out_seen_o,
  output logic [TOT_W-1:0]     out_lost_o,
  output logic [TOT_W-1:0]     out_lines_o
);

  logic [7:0]       mem [LINE_MAX];
  logic [7:0]       rd_q;
  logic [7:0]       rx_q;
  logic             echo_q;
  logic [CNT_W-1:0] limit_q;
  logic [CNT_W-1:0] fill_q, fill_d;
  logic [CNT_W-1:0] len_q, len_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic [TOT_W-1:0] seen_q, seen_d;
  logic [TOT_W-1:0] lost_q, lost_d;
  logic [TOT_W-1:0] lines_q, lines_d;
  logic [CNT_W-1:0] lim;
  logic             mem_we;
  logic             emit;
  logic [7:0]       byte_sel;
  cls_e             cls;

  logic             ov_q;
  kind_e            okind_q;
  logic [7:0]       obyte_q;
  logic [CNT_W-1:0] olen_q;
  logic             olast_q;
  logic [TOT_W-1:0] oseen_q, olost_q, olines_q;

  always_comb begin
    case (rx_i)
      CH_BS:   cls = CLS_BS;
      CH_CR:   cls = CLS_CR;
      CH_LF:   cls = CLS_LF;
      default: cls = CLS_OTHER;
    endcase
  end

  assign lim = (limit_q < CNT_W'(LINE_MAX)) ? limit_q : CNT_W'(LINE_MAX);

  always_comb begin
    fill_d  = fill_q;
    len_d   = len_q;
    idx_d   = idx_q;
    seen_d  = seen_q;
    lost_d  = lost_q;
    lines_d = lines_q;
    mem_we  = 1'b0;
    if (accept_i) begin
      seen_d = seen_q + TOT_W'(1);
    end
    if (ctrl_i.fire) begin
      case (ctrl_i.w.act)
        ACT_STORE: begin
          if (fill_q < lim) begin
            mem_we = 1'b1;
            fill_d = fill_q + CNT_W'(1);
          end else begin
            lost_d = lost_q + TOT_W'(1);
          end
        end
        ACT_BACK: begin
          if (fill_q != '0) begin
            fill_d = fill_q - CNT_W'(1);
          end
        end
        ACT_CLOSE: begin
          lines_d = lines_q + TOT_W'(1);
          len_d   = fill_q;
          idx_d   = '0;
          fill_d  = '0;
        end
        ACT_ADV:  idx_d = idx_q + CNT_W'(1);
        default:  ;
      endcase
    end
  end

  always_comb begin
    case (ctrl_i.w.src)
      SRC_RX:  byte_sel = rx_q;
      SRC_SP:  byte_sel = CH_SP;
      SRC_BS:  byte_sel = CH_BS;
      SRC_LF:  byte_sel = CH_LF;
      SRC_MEM: byte_sel = rd_q;
      default: byte_sel = 8'd0;
    endcase
  end

  assign emit = ctrl_i.fire && ctrl_i.w.emit;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[fill_q[ADDR_W-1:0]] <= rx_q;
    end
    rd_q <= mem[idx_q[ADDR_W-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      echo_q  <= 1'b0;
      limit_q <= CNT_W'(32);
      fill_q  <= '0;
      len_q   <= '0;
      idx_q   <= '0;
      seen_q  <= '0;
      lost_q  <= '0;
      lines_q <= '0;
      ov_q    <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_ECHO:  echo_q  <= cfg_data_i[0];
          CFG_LIMIT: limit_q <= cfg_data_i;
          default:   ;
        endcase
      end
      fill_q  <= fill_d;
      len_q   <= len_d;
      idx_q   <= idx_d;
      seen_q  <= seen_d;
      lost_q  <= lost_d;
      lines_q <= lines_d;
      if (emit) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      rx_q <= rx_i;
    end
    if (emit) begin
      okind_q  <= ctrl_i.w.kind;
      obyte_q  <= byte_sel;
      olen_q   <= (ctrl_i.w.kind == KIND_END) ? len_q : '0;
      olast_q  <= ctrl_i.w.last;
      oseen_q  <= seen_q;
      olost_q  <= lost_q;
      olines_q <= lines_q;
    end
  end

  assign stat_o = '{echo: echo_q, at_end: (idx_q == len_q),
                    out_busy: (ov_q && !out_ready_i), accept: accept_i, cls: cls};

  assign out_valid_o = ov_q;
  assign out_kind_o  = okind_q;
  assign out_byte_o  = obyte_q;
  assign out_len_o   = olen_q;
  assign out_last_o  = olast_q;
  assign out_seen_o  = oseen_q;
  assign out_lost_o  = olost_q;
  assign out_lines_o = olines_q;

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
// Testbench for the console line assembler: directed and random characters checked per result.
`default_nettype none

module tb;
  import cla_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int IDLE_PAUSE = 8;
  localparam int PHASE_ITEMS = 36;

  typedef struct {
    kind_e       kind;
    logic [7:0]  out_byte;
    logic [5:0]  len;
    logic        last;
    logic [31:0] seen;
    logic [31:0] lost;
    logic [31:0] lines;
  } line_result_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [111:0]         m_axis_tdata;
  logic                 m_axis_tlast;
  logic [1:0]           m_axis_tuser;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DAT_W-1:0] cfg_data_i = '0;

  logic [7:0]   rx_pending[$];
  line_result_t line_expect[$];
  line_result_t want;

  logic [7:0]  line_mem [LINE_MAX];
  logic [5:0]  fill_q;
  logic [31:0] seen_q;
  logic [31:0] lost_q;
  logic [31:0] lines_q;
  logic        echo_q;
  logic [5:0]  limit_q;

  int unsigned tx_idle_pct;
  int unsigned rx_stall_pct;
  int unsigned queued_total;
  int unsigned mismatch_count;

  console_line_assembler u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  task automatic report(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] exp_v);
    if (got !== exp_v) begin
      report($sformatf("%s got %0h, want %0h", name, got, exp_v));
    end
  endtask

  function automatic line_result_t make_result(input kind_e k, input logic [7:0] b,
                                               input logic [5:0] n);
    line_result_t r;
    r.kind     = k;
    r.out_byte = b;
    r.len      = n;
    r.last     = 1'b0;
    r.seen     = '0;
    r.lost     = '0;
    r.lines    = '0;
    return r;
  endfunction

  task automatic assemble_char(input logic [7:0] c);
    line_result_t res[$];
    logic [5:0]   lim;
    lim = (limit_q < 6'(LINE_MAX)) ? limit_q : 6'(LINE_MAX);
    seen_q++;
    if (c == CH_LF) return;
    if (echo_q) res.push_back(make_result(KIND_ECHO, c, '0));
    if (c == CH_BS) begin
      if (fill_q != '0) fill_q--;
      if (echo_q) begin
        res.push_back(make_result(KIND_ECHO, CH_SP, '0));
        res.push_back(make_result(KIND_ECHO, CH_BS, '0));
      end
    end else if (c == CH_CR) begin
      if (echo_q) res.push_back(make_result(KIND_ECHO, CH_LF, '0));
      lines_q++;
      for (int i = 0; i < int'(fill_q); i++) begin
        res.push_back(make_result(KIND_LINE, line_mem[ADDR_W'(i)], '0));
      end
      res.push_back(make_result(KIND_END, '0, fill_q));
      fill_q = '0;
    end else if (fill_q < lim) begin
      line_mem[fill_q[ADDR_W-1:0]] = c;
      fill_q++;
    end else begin
      lost_q++;
    end
    foreach (res[k]) begin
      res[k].last  = (k == res.size() - 1);
      res[k].seen  = seen_q;
      res[k].lost  = lost_q;
      res[k].lines = lines_q;
      line_expect.push_back(res[k]);
    end
  endtask

  // Present the oldest pending character; hold it until the transaction completes.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else if (!(s_axis_tvalid && !s_axis_tready)) begin
      if (s_axis_tvalid) begin
        assemble_char(s_axis_tdata);
        void'(rx_pending.pop_front());
      end
      if (rx_pending.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= rx_pending[0];
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (line_expect.size() == 0) begin
          report($sformatf("unexpected result, kind %0d byte %0h",
                           m_axis_tuser, m_axis_tdata[7:0]));
        end else begin
          want = line_expect.pop_front();
          check_field("kind", 32'(m_axis_tuser), 32'(want.kind));
          check_field("out_byte", 32'(m_axis_tdata[7:0]), 32'(want.out_byte));
          check_field("line_length", 32'(m_axis_tdata[13:8]), 32'(want.len));
          check_field("last", 32'(m_axis_tlast), 32'(want.last));
          check_field("chars_seen", m_axis_tdata[45:14], want.seen);
          check_field("chars_lost", m_axis_tdata[77:46], want.lost);
          check_field("lines_done", m_axis_tdata[109:78], want.lines);
        end
      end
      m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  task automatic push_char(input logic [7:0] c);
    rx_pending.push_back(c);
    queued_total++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] d);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_ECHO:  echo_q = d[0];
      CFG_LIMIT: limit_q = d;
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_idle();
    while (rx_pending.size() != 0 || line_expect.size() != 0 || s_axis_tvalid) begin
      @(posedge clk_i);
    end
    repeat (IDLE_PAUSE) @(posedge clk_i);
  endtask

  // Mostly text, the odd backspace, closed by carriage return.
  task automatic queue_line(input int unsigned len);
    logic [7:0] c;
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(9) == 0) begin
        push_char(CH_BS);
      end else begin
        do begin
          c = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(32, 126));
        end while (c == CH_BS || c == CH_CR || c == CH_LF);
        push_char(c);
      end
    end
    push_char(CH_CR);
  endtask

  initial begin
    int unsigned start;
    fill_q         = '0;
    seen_q         = '0;
    lost_q         = '0;
    lines_q        = '0;
    echo_q         = 1'b0;
    limit_q        = 6'd32;
    queued_total   = 0;
    mismatch_count = 0;
    tx_idle_pct    = 37;
    rx_stall_pct   = 76;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Echo off, reset limit: zero byte stored, backspace on an empty line.
    push_char("a");
    push_char(8'h00);
    push_char(8'hFF);
    push_char(CH_LF);
    push_char(CH_BS);
    push_char(CH_CR);
    push_char(CH_BS);
    push_char(CH_CR);
    wait_idle();

    write_reg(CFG_ECHO, 6'h01);
    write_reg(CFG_LIMIT, 6'd3);
    push_char("x");
    push_char("y");
    push_char("z");
    push_char("w");
    push_char(CH_BS);
    push_char("q");
    push_char(CH_CR);
    push_char(CH_LF);
    wait_idle();

    write_reg(CFG_LIMIT, 6'd0);
    write_reg(CFG_SPARE, 6'h3F);
    push_char("k");
    push_char(CH_BS);
    push_char(CH_CR);
    wait_idle();

    write_reg(CFG_ECHO, 6'h3E);
    write_reg(CFG_LIMIT, 6'h3F);
    push_char(8'h80);
    push_char(8'h7F);
    push_char(8'h55);
    push_char(8'hAA);
    push_char(8'h01);
    wait_idle();

    // Lower the limit below the current fill; the stored line survives.
    write_reg(CFG_LIMIT, 6'd2);
    push_char("m");
    push_char(CH_CR);
    wait_idle();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph / 2)
        0: begin
          tx_idle_pct  = 37;
          rx_stall_pct = 76;
        end
        1: begin
          tx_idle_pct  = 76;
          rx_stall_pct = 37;
        end
        default: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 0;
        end
      endcase
      write_reg(CFG_ECHO, 6'($urandom_range(63)));
      case ($urandom_range(5))
        0: write_reg(CFG_LIMIT, 6'd0);
        1: write_reg(CFG_LIMIT, 6'd1);
        2: write_reg(CFG_LIMIT, 6'd32);
        3: write_reg(CFG_LIMIT, 6'h3F);
        default: write_reg(CFG_LIMIT, 6'($urandom_range(63)));
      endcase
      start = queued_total;
      while (queued_total - start < PHASE_ITEMS) begin
        if ($urandom_range(4) != 0) begin
          if ($urandom_range(7) == 0) queue_line($urandom_range(40));
          else queue_line($urandom_range(8));
        end else begin
          case ($urandom_range(5))
            0: push_char(CH_LF);
            1: push_char(CH_BS);
            2: push_char(CH_CR);
            default: push_char(8'($urandom_range(255)));
          endcase
        end
      end
      wait_idle();
    end

    if (line_expect.size() != 0) begin
      report($sformatf("%0d results never arrived", line_expect.size()));
    end
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

`default_nettype wire

// ----- files.f -----
design/cla_pkg.sv
design/cla_useq.sv
design/cla_datapath.sv
design/console_line_assembler.sv
tb/sv/tb.sv
